>>> rtl/mmul_pkg.sv
// shared constants and types for the 256-bit montgomery multiplier
`timescale 1ns / 1ps
package mmul_pkg;

  // number of limbs per operand, fixed by the named limb fields
  localparam int LimbCount = 4;
  // width of every limb field on the ports
  localparam int FieldWidth = 64;
  // default limb width used inside the datapath
  localparam int LimbWidthDefault = 64;

  // configuration register index
  localparam int CfgIdxWidth = 3;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

  // register index of the negated modulus inverse, the modulus limbs sit below it
  localparam cfg_idx_t CfgNegInvIdx = cfg_idx_t'(LimbCount);

endpackage

>>> rtl/mmul_if.sv
// valid/ready channels for operand items and product items
`timescale 1ns / 1ps

interface mmul_in_if import mmul_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FieldWidth-1:0] a_limb0;
  logic [FieldWidth-1:0] a_limb1;
  logic [FieldWidth-1:0] a_limb2;
  logic [FieldWidth-1:0] a_limb3;
  logic [FieldWidth-1:0] b_limb0;
  logic [FieldWidth-1:0] b_limb1;
  logic [FieldWidth-1:0] b_limb2;
  logic [FieldWidth-1:0] b_limb3;

  modport source (
    output valid, a_limb0, a_limb1, a_limb2, a_limb3,
    output b_limb0, b_limb1, b_limb2, b_limb3,
    input  ready
  );
  modport sink (
    input  valid, a_limb0, a_limb1, a_limb2, a_limb3,
    input  b_limb0, b_limb1, b_limb2, b_limb3,
    output ready
  );
endinterface

interface mmul_out_if import mmul_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FieldWidth-1:0] product_limb0;
  logic [FieldWidth-1:0] product_limb1;
  logic [FieldWidth-1:0] product_limb2;
  logic [FieldWidth-1:0] product_limb3;

  modport source (
    output valid, product_limb0, product_limb1, product_limb2, product_limb3,
    input  ready
  );
  modport sink (
    input  valid, product_limb0, product_limb1, product_limb2, product_limb3,
    output ready
  );
endinterface

>>> rtl/mmul_cell.sv
// one row cell: adds x * y shifted by ROW limbs into the running accumulator
`timescale 1ns / 1ps
module mmul_cell import mmul_pkg::*; #(
  parameter int LIMB_WIDTH = LimbWidthDefault,
  parameter bit REDUCE     = 1'b0,
  parameter int ROW        = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [LimbCount*LIMB_WIDTH-1:0]   a_i,
  input  logic [LimbCount*LIMB_WIDTH-1:0]   b_i,
  input  logic [(2*LimbCount+1)*LIMB_WIDTH-1:0] t_i,
  input  logic [LimbCount*LIMB_WIDTH-1:0]   mod_i,
  input  logic [LIMB_WIDTH-1:0]             ninv_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [LimbCount*LIMB_WIDTH-1:0]   a_o,
  output logic [LimbCount*LIMB_WIDTH-1:0]   b_o,
  output logic [(2*LimbCount+1)*LIMB_WIDTH-1:0] t_o
);

  localparam int W   = LIMB_WIDTH;
  localparam int L   = LimbCount;
  localparam int OW  = L * W;
  localparam int TW  = (2 * L + 1) * W;
  localparam int H   = W / 2;
  localparam int G   = W - H;
  localparam int S   = REDUCE ? 5 : 3;
  localparam int PB  = REDUCE ? 2 : 0;

  // stage valids and load enables, bubbles collapse toward the output
  logic [S-1:0] vld_q;
  logic [S:0]   ld;
  logic [OW-1:0] a_q [S];
  logic [OW-1:0] b_q [S];
  logic [TW-1:0] t_q [S];

  // multiplier operands and partial products
  logic [W-1:0]   x_src;
  logic [OW-1:0]  y_src;
  logic [2*H-1:0] pll_q [L];
  logic [H+G-1:0] plh_q [L];
  logic [G+H-1:0] phl_q [L];
  logic [2*G-1:0] phh_q [L];
  logic [2*W-1:0] prod_q [L];
  logic [TW-1:0]  even_w;
  logic [TW-1:0]  odd_w;
  logic [TW-1:0]  sum_w;

  // ready ripples back from the output stage
  always_comb begin
    ld[S] = ready_i;
    for (int k = S - 1; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  assign ready_o = ld[0];
  assign valid_o = vld_q[S-1];
  assign a_o     = a_q[S-1];
  assign b_o     = b_q[S-1];
  assign t_o     = t_q[S-1];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < S; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // operands and accumulator travel along with the item
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < S; k++) begin
      if (ld[k]) begin
        if (k == 0) begin
          a_q[k] <= a_i;
          b_q[k] <= b_i;
          t_q[k] <= t_i;
        end else begin
          a_q[k] <= a_q[k-1];
          b_q[k] <= b_q[k-1];
          t_q[k] <= (k == S - 1) ? sum_w : t_q[k-1];
        end
      end
    end
  end

  // quotient digit for reduction rows, otherwise the row limb of a
  generate
    if (REDUCE) begin : g_quot
      logic [2*H-1:0] ml_ll_q;
      logic [G-1:0]   ml_lh_q;
      logic [G-1:0]   ml_hl_q;
      logic [W-1:0]   m_q;
      logic [W-1:0]   tx;

      assign tx = t_i[W*ROW +: W];

      // low word of t limb times the negated inverse, split in halves
      always_ff @(posedge clk_i) begin
        if (ld[0]) begin
          ml_ll_q <= (2*H)'(tx[H-1:0]) * (2*H)'(ninv_i[H-1:0]);
          ml_lh_q <= G'(G'(tx[H-1:0]) * ninv_i[W-1:H]);
          ml_hl_q <= G'(tx[W-1:H] * G'(ninv_i[H-1:0]));
        end
        if (ld[1]) begin
          m_q <= W'(ml_ll_q) + (W'(G'(ml_lh_q + ml_hl_q)) << H);
        end
      end

      assign x_src = m_q;
      assign y_src = mod_i;
    end else begin : g_row
      assign x_src = a_i[W*ROW +: W];
      assign y_src = b_i;
    end
  endgenerate

  // half-word partial products of x times every limb of y
  always_ff @(posedge clk_i) begin
    if (ld[PB]) begin
      for (int j = 0; j < L; j++) begin
        pll_q[j] <= (2*H)'(x_src[H-1:0]) * (2*H)'(y_src[W*j +: H]);
        plh_q[j] <= (H+G)'(x_src[H-1:0]) * (H+G)'(y_src[W*j+H +: G]);
        phl_q[j] <= (H+G)'(x_src[W-1:H]) * (H+G)'(y_src[W*j +: H]);
        phh_q[j] <= (2*G)'(x_src[W-1:H]) * (2*G)'(y_src[W*j+H +: G]);
      end
    end
  end

  // combine partials into full limb products
  always_ff @(posedge clk_i) begin
    if (ld[PB+1]) begin
      for (int j = 0; j < L; j++) begin
        prod_q[j] <= (2*W)'(pll_q[j]) + ((2*W)'(plh_q[j]) << H)
                   + ((2*W)'(phl_q[j]) << H) + ((2*W)'(phh_q[j]) << (2*H));
      end
    end
  end

  // even and odd limb products do not overlap, so two rows cover them
  always_comb begin
    even_w = '0;
    odd_w  = '0;
    for (int j = 0; j < L; j++) begin
      if ((j & 1) == 0) begin
        even_w[W*(ROW+j) +: 2*W] = prod_q[j];
      end else begin
        odd_w[W*(ROW+j) +: 2*W] = prod_q[j];
      end
    end
    sum_w = t_q[S-2] + even_w + odd_w;
  end

endmodule

>>> rtl/mmul_final.sv
// final conditional subtraction of the modulus and output register
`timescale 1ns / 1ps
module mmul_final import mmul_pkg::*; #(
  parameter int LIMB_WIDTH = LimbWidthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [(2*LimbCount+1)*LIMB_WIDTH-1:0] t_i,
  input  logic [LimbCount*LIMB_WIDTH-1:0]       mod_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [LimbCount*LIMB_WIDTH-1:0]       res_o
);

  localparam int W  = LIMB_WIDTH;
  localparam int OW = LimbCount * W;
  localparam int TW = (2 * LimbCount + 1) * W;
  localparam int UW = OW + W;

  logic          vld_q;
  logic [OW-1:0] res_q;
  logic [UW-1:0] upper;
  logic [UW:0]   diff;
  logic          ge;

  // upper half with top limb against p, borrow out means below p
  assign upper = t_i[TW-1:OW];
  assign diff  = {1'b0, upper} - (UW+1)'(mod_i);
  assign ge    = !diff[UW];

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      res_q <= ge ? diff[OW-1:0] : upper[OW-1:0];
    end
  end

endmodule

>>> rtl/montgomery_mult_256.sv
// top level of the pipelined 256-bit montgomery multiplier
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-------------------------------------
//  in_i     | in  | valid / ready  | a_limb0..3, b_limb0..3
//  out_o    | out | valid / ready  | product_limb0..3
//  cfg      | in  | cfg_we_i       | cfg_idx_i, cfg_data_i (p limbs, -p^-1)
//
// one item per cycle while the output is not stalled; the pipeline is four product cells of 3 stages,
// four reduction cells of 5 stages (quotient multiply, then limb multiply)
// and one subtract stage
// reset clears valids and config registers, the pipeline starts empty
// each stage holds while the next is full and stalled, so empty stages
// behind a waiting result keep filling
`timescale 1ns / 1ps
module montgomery_mult_256 import mmul_pkg::*; #(
  parameter int LIMB_WIDTH = LimbWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mmul_in_if.sink               in_i,
  mmul_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  cfg_idx_t              cfg_idx_i,
  input  logic [FieldWidth-1:0] cfg_data_i
);

  localparam int W  = LIMB_WIDTH;
  localparam int L  = LimbCount;
  localparam int OW = L * W;
  localparam int TW = (2 * L + 1) * W;
  localparam int NC = 2 * L;

  // configuration registers
  logic [OW-1:0] mod_q;
  logic [W-1:0]  ninv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= '0;
      ninv_q <= '0;
    end else if (cfg_we_i) begin
      for (int k = 0; k < L; k++) begin
        if (cfg_idx_i == cfg_idx_t'(k)) begin
          mod_q[W*k +: W] <= cfg_data_i[W-1:0];
        end
      end
      if (cfg_idx_i == CfgNegInvIdx) begin
        ninv_q <= cfg_data_i[W-1:0];
      end
    end
  end

  // links between cells
  logic          vld_w [NC+1];
  logic          rdy_w [NC+1];
  logic [OW-1:0] a_w   [NC+1];
  logic [OW-1:0] b_w   [NC+1];
  logic [TW-1:0] t_w   [NC+1];
  logic [OW-1:0] res_w;

  assign vld_w[0]  = in_i.valid;
  assign in_i.ready = rdy_w[0];
  assign a_w[0] = {in_i.a_limb3[W-1:0], in_i.a_limb2[W-1:0],
                   in_i.a_limb1[W-1:0], in_i.a_limb0[W-1:0]};
  assign b_w[0] = {in_i.b_limb3[W-1:0], in_i.b_limb2[W-1:0],
                   in_i.b_limb1[W-1:0], in_i.b_limb0[W-1:0]};
  assign t_w[0] = '0;

  // product rows first, then reduction rows
  for (genvar c = 0; c < NC; c++) begin : g_cell
    mmul_cell #(
      .LIMB_WIDTH (W),
      .REDUCE     (c >= L),
      .ROW        ((c >= L) ? c - L : c)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_w[c]),
      .ready_o (rdy_w[c]),
      .a_i     (a_w[c]),
      .b_i     (b_w[c]),
      .t_i     (t_w[c]),
      .mod_i   (mod_q),
      .ninv_i  (ninv_q),
      .valid_o (vld_w[c+1]),
      .ready_i (rdy_w[c+1]),
      .a_o     (a_w[c+1]),
      .b_o     (b_w[c+1]),
      .t_o     (t_w[c+1])
    );
  end

  // conditional subtraction and result register
  mmul_final #(
    .LIMB_WIDTH (W)
  ) u_final (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_w[NC]),
    .ready_o (rdy_w[NC]),
    .t_i     (t_w[NC]),
    .mod_i   (mod_q),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res_w)
  );

  assign out_o.product_limb0 = FieldWidth'(res_w[0*W +: W]);
  assign out_o.product_limb1 = FieldWidth'(res_w[1*W +: W]);
  assign out_o.product_limb2 = FieldWidth'(res_w[2*W +: W]);
  assign out_o.product_limb3 = FieldWidth'(res_w[3*W +: W]);

  // a taken result frees the whole chain for a new item
  a_out_ready_frees_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_o.ready |-> in_i.ready
  ) else $error("input stalled while output is taken");

  // the input only stalls when the chain is full behind a waiting result
  a_stall_needs_full_out: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready)
  ) else $error("input stalled without a waiting result");

  // a result leaves the final stage only when consumed
  a_result_not_lost: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid
  ) else $error("waiting result dropped");

endmodule

>>> tb/tb_montgomery_mult_256.sv
// testbench for the pipelined 256-bit montgomery multiplier
`timescale 1ns / 1ps

// expected product store and checker
class mont_scoreboard;
  logic [255:0] pending_q[$];
  int unsigned  mismatches;
  int unsigned  checked;

  function void note_operands(logic [255:0] expected);
    pending_q.push_back(expected);
  endfunction

  function void check_product(logic [255:0] actual);
    logic [255:0] expected;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected product %h", actual);
      return;
    end
    expected = pending_q.pop_front();
    checked++;
    for (int i = 0; i < 4; i++) begin
      if (expected[64*i +: 64] !== actual[64*i +: 64]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("product_limb%0d mismatch: expected %h actual %h", i,
                   expected[64*i +: 64], actual[64*i +: 64]);
      end
    end
  endfunction
endclass

module tb_montgomery_mult_256;
  import mmul_pkg::*;

  localparam int Latency = 33;
  localparam int IdleLimit = 20000;
  localparam int RandomItems = 390;
  localparam logic [255:0] P256 =
    256'hffffffff00000001000000000000000000000000ffffffffffffffffffffffff;
  localparam logic [255:0] Secp =
    256'hfffffffffffffffffffffffffffffffffffffffffffffffffffffffefffffc2f;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_t              cfg_idx_i;
  logic [FieldWidth-1:0] cfg_data_i;

  mmul_in_if  in_if ();
  mmul_out_if out_if ();

  montgomery_mult_256 dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if.sink),
    .out_o     (out_if.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  mont_scoreboard sb;
  logic [255:0] modulus;
  logic [63:0]  neg_inv;
  int unsigned  sent;
  int unsigned  idle_cycles;
  int unsigned  stall_mode;
  logic         timed_out;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // montgomery product as the block computes it, with the modulus and inverse held here
  function automatic logic [255:0] mont_product(logic [255:0] a, logic [255:0] b);
    logic [512:0] t;
    logic [63:0]  m;
    logic         ge;
    t = a * b;
    for (int i = 0; i < 4; i++) begin
      m = t[64*i +: 64] * neg_inv;
      t = t + ((({449'b0, m} * {257'b0, modulus})) << (64 * i));
    end
    ge = t[512] || (t[511:256] >= modulus);
    return ge ? t[511:256] - modulus : t[511:256];
  endfunction

  // negated inverse of the low limb of the modulus
  function automatic logic [63:0] neg_inverse(logic [63:0] p0);
    logic [63:0] x;
    x = 64'd1;
    for (int i = 0; i < 7; i++) x = x * (64'd2 - p0 * x);
    return -x;
  endfunction

  function automatic logic [255:0] rand256();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // register write, block is idle; the caller drops the enable afterwards
  task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_field(logic [255:0] p, logic [63:0] ninv);
    for (int i = 0; i < LimbCount; i++) write_reg(cfg_idx_t'(i), p[64*i +: 64]);
    write_reg(CfgNegInvIdx, ninv);
    cfg_we_i <= 1'b0;
    modulus = p;
    neg_inv = ninv;
  endtask

  // one operand item, held until accepted
  task automatic send_item(logic [255:0] a, logic [255:0] b);
    in_if.valid   <= 1'b1;
    in_if.a_limb0 <= a[63:0];
    in_if.a_limb1 <= a[127:64];
    in_if.a_limb2 <= a[191:128];
    in_if.a_limb3 <= a[255:192];
    in_if.b_limb0 <= b[63:0];
    in_if.b_limb1 <= b[127:64];
    in_if.b_limb2 <= b[191:128];
    in_if.b_limb3 <= b[255:192];
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_operands(mont_product(a, b));
    sent++;
  endtask

  task automatic gap(int unsigned n);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // random stream in bursts, operands mostly below the modulus
  task automatic random_phase(int unsigned count);
    int unsigned burst;
    logic [255:0] a, b;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && count > 0; k++) begin
        a = rand256();
        b = rand256();
        if ($urandom_range(0, 9) != 0 && modulus != 0) begin
          a = a % modulus;
          b = b % modulus;
        end
        send_item(a, b);
        count--;
      end
      gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
    end
    gap(1);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // receiver stalls, pattern changes over time
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_mode   <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= ($urandom_range(0, 1) != 0);
        default: out_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // product check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_product({out_if.product_limb3, out_if.product_limb2,
                          out_if.product_limb1, out_if.product_limb0});
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog: no handshake for %0d cycles", IdleLimit);
      $display("FAIL montgomery_mult_256");
      $finish;
    end
  end

  initial begin
    logic [255:0] p_rand;
    sb = new();
    timed_out   = 1'b0;
    idle_cycles = 0;
    sent        = 0;
    modulus     = '0;
    neg_inv     = '0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_if.valid = 1'b0;
    {in_if.a_limb0, in_if.a_limb1, in_if.a_limb2, in_if.a_limb3} = '0;
    {in_if.b_limb0, in_if.b_limb1, in_if.b_limb2, in_if.b_limb3} = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: zero modulus
    send_item(rand256(), rand256());
    gap(1);
    drain();

    // directed items on the p-256 field
    load_field(P256, neg_inverse(P256[63:0]));
    send_item('0, '0);
    send_item(256'd1, 256'd1);
    send_item(P256 - 1, P256 - 1);
    send_item(P256 - 1, 256'd1);
    send_item(P256, P256);
    send_item('1, '1);
    send_item('1, 256'd1);
    send_item({4{64'h8000000000000000}}, {4{64'h7fffffffffffffff}});
    send_item({4{64'h5555555555555555}}, {4{64'haaaaaaaaaaaaaaaa}});
    send_item(256'd1 << 255, 256'd2);
    gap(1);
    drain();

    // even modulus and inconsistent inverse
    load_field({4{64'hfffffffffffffffe}}, 64'h123456789abcdef0);
    send_item('1, '1);
    send_item({4{64'haaaaaaaaaaaaaaaa}}, {4{64'h5555555555555555}});
    send_item(256'd3, '1);
    gap(1);
    drain();

    // all-ones registers
    load_field('1, '1);
    random_phase(20);
    drain();

    // random odd modulus with its inverse
    p_rand = rand256() | 256'd1;
    load_field(p_rand, neg_inverse(p_rand[63:0]));
    random_phase(RandomItems / 3);
    drain();

    // small odd modulus, most operands reduced to zero, the rest above it
    load_field(256'd1, neg_inverse(64'd1));
    random_phase(20);
    drain();

    load_field(Secp, neg_inverse(Secp[63:0]));
    random_phase(RandomItems / 3);
    drain();

    load_field(P256, neg_inverse(P256[63:0]));
    random_phase(RandomItems / 3);
    drain();

    $display("run covered %0d operand items over seven register settings, %0d products checked",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("PASS montgomery_mult_256");
    end else begin
      $display("%0d mismatches, %0d products missing", sb.mismatches, sb.pending_q.size());
      $display("FAIL montgomery_mult_256");
    end
    $finish;
  end

endmodule
